// File: rtl/ltc_pkg.sv
package ltc_pkg;

  // Sizes
  localparam int MAX_TYPES  = 16;
  localparam int TYPE_W     = 4;
  localparam int NT_W       = 5;
  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int CUT_W      = 50;
  localparam int CNT_W      = 11;
  localparam int FRAC_W     = 17;
  localparam int STEP_W     = 5;

  localparam logic [CNT_W-1:0]  TALLY_MAX     = 11'd1025;
  localparam logic [NT_W-1:0]   MAX_TYPES_NT  = 5'd16;
  localparam logic [STEP_W-1:0] DIV_LAST_STEP = 5'(FRAC_W - 1);

  // Configuration register indexes
  localparam logic CFG_CUTOFF    = 1'b0;
  localparam logic CFG_NUM_TYPES = 1'b1;

  // Command codes
  localparam logic CMD_CENTER   = 1'b0;
  localparam logic CMD_NEIGHBOR = 1'b1;

  // Axis codes for the shared squarer
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic                         cmd;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [TYPE_W-1:0]            atom_type;
    logic                         in_group;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic [TYPE_W-1:0] type_index;
    logic [CNT_W-1:0]  type_count;
    logic [CNT_W-1:0]  total_count;
    logic [FRAC_W-1:0] fraction;
    logic              last_result;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CMP,
    ST_LAST,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_EMIT
  } state_e;

endpackage

// File: rtl/local_type_composition.sv
// Sequencing: busy_o covers the list-end check for a center item, and three squarer
//   passes, one compare and the list-end check for a neighbor item; start_i is taken
//   only while busy_o is low. An in-group list end then runs, per type: load, 17 divider
//   steps, emit; each result strobes from a register after its emit state.
// Throughput: shared 25x25 squarer, one-bit-a-cycle divider; one-cycle strobe, no stall.
// Reset clears all tallies, center state and the FSM; registers return to cutoff 0, 1 type.
module local_type_composition (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  ltc_pkg::item_t             item_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [ltc_pkg::CUT_W-1:0]  cfg_data_i,
  output ltc_pkg::result_t           result_o,
  output logic                       result_valid_o
);

  ltc_pkg::state_e state_q, state_d;

  logic [ltc_pkg::CUT_W-1:0]           cutoff_q;
  logic [ltc_pkg::NT_W-1:0]            num_types_q;
  ltc_pkg::item_t                      item_q;
  logic signed [ltc_pkg::COORD_BITS-1:0] cx_q, cy_q, cz_q;
  logic                                grp_q;
  logic [ltc_pkg::CNT_W-1:0]           total_q;
  logic [ltc_pkg::CNT_W-1:0]           tally_q [ltc_pkg::MAX_TYPES];
  logic [1:0]                          axis_q;
  logic [ltc_pkg::ACC_W-1:0]           acc_q;
  logic [ltc_pkg::TYPE_W-1:0]          k_q;
  logic [ltc_pkg::CNT_W-1:0]           tc_q;
  logic [ltc_pkg::CNT_W-1:0]           rem_q;
  logic [ltc_pkg::FRAC_W-1:0]          dlo_q;
  logic [ltc_pkg::FRAC_W-1:0]          quot_q;
  logic [ltc_pkg::STEP_W-1:0]          step_q;
  ltc_pkg::result_t                    res_q;
  logic                                res_valid_q;

  logic                                accept;
  logic [ltc_pkg::NT_W-1:0]            nt;
  logic                                type_ok;
  logic [ltc_pkg::TYPE_W-1:0]          rd_addr;
  logic [ltc_pkg::CNT_W-1:0]           rd_tally;
  logic signed [ltc_pkg::COORD_BITS-1:0] sel_c, sel_p;
  logic signed [ltc_pkg::DIFF_W-1:0]   diff;
  logic [ltc_pkg::DIFF_W-1:0]          adiff;
  logic [ltc_pkg::PROD_W-1:0]          prod;
  logic                                hit;
  logic [ltc_pkg::CNT_W:0]             shifted;
  logic                                ge;
  logic [ltc_pkg::CNT_W:0]             sub;
  logic                                last_type;
  logic                                emit_list;
  logic                                div_done;

  // Types in use, clamped to the histogram size
  assign nt = (num_types_q > ltc_pkg::MAX_TYPES_NT) ? ltc_pkg::MAX_TYPES_NT : num_types_q;

  // Handshake and sequencer status
  always_comb begin
    busy_o    = (state_q != ltc_pkg::ST_IDLE);
    accept    = start_i && !busy_o;
    type_ok   = ({1'b0, item_q.atom_type} < nt);
    last_type = ({1'b0, k_q} + ltc_pkg::NT_W'(1)) == nt;
    emit_list = item_q.last && grp_q && (nt != '0);
    div_done  = (step_q == ltc_pkg::DIV_LAST_STEP);
  end

  // Single read port on the tally file
  assign rd_addr  = (state_q == ltc_pkg::ST_DIV_LOAD) ? k_q : item_q.atom_type;
  assign rd_tally = tally_q[rd_addr];

  // Shared squarer: one axis per pass
  always_comb begin
    case (axis_q)
      ltc_pkg::AXIS_X: begin sel_c = cx_q; sel_p = item_q.pos_x; end
      ltc_pkg::AXIS_Y: begin sel_c = cy_q; sel_p = item_q.pos_y; end
      default:         begin sel_c = cz_q; sel_p = item_q.pos_z; end
    endcase
    diff  = {sel_c[ltc_pkg::COORD_BITS-1], sel_c} - {sel_p[ltc_pkg::COORD_BITS-1], sel_p};
    adiff = diff[ltc_pkg::DIFF_W-1] ? ltc_pkg::DIFF_W'(-diff) : ltc_pkg::DIFF_W'(diff);
    prod  = adiff * adiff;
  end

  assign hit = (acc_q < {{(ltc_pkg::ACC_W-ltc_pkg::CUT_W){1'b0}}, cutoff_q});

  // Restoring divider step
  always_comb begin
    shifted = {rem_q, dlo_q[ltc_pkg::FRAC_W-1]};
    ge      = (shifted >= {1'b0, total_q});
    sub     = shifted - {1'b0, total_q};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ltc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (item_i.cmd == ltc_pkg::CMD_CENTER) ? ltc_pkg::ST_LAST : ltc_pkg::ST_SQ;
        end
      end
      ltc_pkg::ST_SQ: begin
        if (axis_q == ltc_pkg::AXIS_Z) state_d = ltc_pkg::ST_CMP;
      end
      ltc_pkg::ST_CMP:      state_d = ltc_pkg::ST_LAST;
      ltc_pkg::ST_LAST:     state_d = emit_list ? ltc_pkg::ST_DIV_LOAD : ltc_pkg::ST_IDLE;
      ltc_pkg::ST_DIV_LOAD: state_d = ltc_pkg::ST_DIV_STEP;
      ltc_pkg::ST_DIV_STEP: begin
        if (div_done) state_d = ltc_pkg::ST_EMIT;
      end
      ltc_pkg::ST_EMIT:     state_d = last_type ? ltc_pkg::ST_IDLE : ltc_pkg::ST_DIV_LOAD;
      default:              state_d = ltc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ltc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q    <= '0;
      num_types_q <= ltc_pkg::NT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ltc_pkg::CFG_CUTOFF:    cutoff_q    <= cfg_data_i;
        ltc_pkg::CFG_NUM_TYPES: num_types_q <= cfg_data_i[ltc_pkg::NT_W-1:0];
        default: ;
      endcase
    end
  end

  // Center state and tallies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      grp_q   <= 1'b0;
      total_q <= '0;
      for (int i = 0; i < ltc_pkg::MAX_TYPES; i++) tally_q[i] <= '0;
    end else if (accept && (item_i.cmd == ltc_pkg::CMD_CENTER)) begin
      cx_q    <= item_i.pos_x;
      cy_q    <= item_i.pos_y;
      cz_q    <= item_i.pos_z;
      grp_q   <= item_i.in_group;
      total_q <= ltc_pkg::CNT_W'(1);
      // clear all tallies, the center counts under its own type if that type is in use
      for (int i = 0; i < ltc_pkg::MAX_TYPES; i++) begin
        tally_q[i] <= ((ltc_pkg::TYPE_W'(i) == item_i.atom_type) &&
                       ({1'b0, item_i.atom_type} < nt)) ? ltc_pkg::CNT_W'(1) : '0;
      end
    end else if ((state_q == ltc_pkg::ST_CMP) && hit) begin
      if (total_q < ltc_pkg::TALLY_MAX) total_q <= total_q + ltc_pkg::CNT_W'(1);
      if (type_ok && (rd_tally < ltc_pkg::TALLY_MAX)) begin
        tally_q[item_q.atom_type] <= rd_tally + ltc_pkg::CNT_W'(1);
      end
    end
  end

  // Item latch, squarer accumulation, divider datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
      axis_q <= ltc_pkg::AXIS_X;
      acc_q  <= '0;
    end
    if (state_q == ltc_pkg::ST_SQ) begin
      acc_q  <= acc_q + ltc_pkg::ACC_W'(prod);
      axis_q <= axis_q + 2'd1;
    end
    if (state_q == ltc_pkg::ST_LAST) k_q <= '0;
    if (state_q == ltc_pkg::ST_EMIT) k_q <= k_q + ltc_pkg::TYPE_W'(1);
    if (state_q == ltc_pkg::ST_DIV_LOAD) begin
      tc_q   <= rd_tally;
      rem_q  <= {1'b0, rd_tally[ltc_pkg::CNT_W-1:1]};
      dlo_q  <= {rd_tally[0], {(ltc_pkg::FRAC_W-1){1'b0}}};
      quot_q <= '0;
      step_q <= '0;
    end
    if (state_q == ltc_pkg::ST_DIV_STEP) begin
      rem_q  <= ge ? sub[ltc_pkg::CNT_W-1:0] : shifted[ltc_pkg::CNT_W-1:0];
      quot_q <= {quot_q[ltc_pkg::FRAC_W-2:0], ge};
      dlo_q  <= {dlo_q[ltc_pkg::FRAC_W-2:0], 1'b0};
      step_q <= step_q + ltc_pkg::STEP_W'(1);
    end
    if (state_q == ltc_pkg::ST_EMIT) begin
      res_q.type_index  <= k_q;
      res_q.type_count  <= tc_q;
      res_q.total_count <= total_q;
      res_q.fraction    <= (total_q == '0) ? '0 : quot_q;
      res_q.last_result <= last_type;
    end
  end

  // One-cycle result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == ltc_pkg::ST_EMIT);
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_strobe_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (state_q == ltc_pkg::ST_IDLE || state_q == ltc_pkg::ST_DIV_LOAD))
    else $error("result strobe outside emit sequence");

  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.type_count <= result_o.total_count))
    else $error("type count exceeds total count");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_result) |-> !busy_o)
    else $error("sequencer still busy after final result");
`endif

endmodule
